FILE: sv/saar_pkg.sv
// Shared types, constants and helper functions of the stereo allpass reverb.
package saar_pkg;

  localparam int DELAY_DEPTH_DEF  = 1024;
  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int COEF_W      = 16;
  localparam int TAP_W       = 10;
  localparam int CFG_INDEX_W = 8;
  localparam int STAGES      = 4;
  localparam int STAGE_W     = $clog2(STAGES);

  // Stage whose output feeds the left channel
  localparam logic [STAGE_W-1:0] LEFT_STAGE = STAGE_W'(2);
  localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGES - 1);

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_DAMP_COEF     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_DRY_GAIN      = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_WET_GAIN      = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_COEF = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_ONE       = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_TWO       = CFG_INDEX_W'(5);
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_THREE     = CFG_INDEX_W'(6);
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_FOUR      = CFG_INDEX_W'(7);

  // Register reset values
  localparam logic [COEF_W-1:0] DAMP_COEF_RST     = COEF_W'(44564);
  localparam logic [COEF_W-1:0] DRY_GAIN_RST      = COEF_W'(778);
  localparam logic [COEF_W-1:0] WET_GAIN_RST      = COEF_W'(2949);
  localparam logic [COEF_W-1:0] FEEDBACK_COEF_RST = COEF_W'(52429);
  localparam logic [TAP_W-1:0]  TAP_RST [STAGES] = '{
    TAP_W'(202), TAP_W'(268), TAP_W'(523), TAP_W'(716)
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DAMP,
    ST_FILT,
    ST_AP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               accept;
    logic               clr;
    logic               mul;
    logic               damp;
    logic               filt;
    logic               ap;
    logic [STAGE_W-1:0] stage;
    logic               load;
  } cmd_t;

  typedef struct packed {
    logic rp_last;
  } status_t;

  // Reduce a tap below the line depth by a few conditional subtractions
  function automatic int tap_mod(input int tap, input int depth);
    int t;
    t = tap;
    for (int s = 3; s >= 0; s--) begin
      if (t >= (depth << s)) begin
        t = t - (depth << s);
      end
    end
    return t;
  endfunction

endpackage

FILE: sv/saar_ram.sv
// Generic simple dual-port RAM with registered read.
module saar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/saar_ctrl.sv
// Sequencing state machine of the stereo allpass reverb.
module saar_ctrl import saar_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t             state, state_next;
  logic [STAGE_W-1:0] stage, stage_next;
  logic               out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      stage     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      stage     <= stage_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    stage_next = '0;
    unique case (state)
      ST_CLEAR: begin
        if (status.rp_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_DAMP;
      ST_DAMP: state_next = ST_FILT;
      ST_FILT: state_next = ST_AP;
      ST_AP: begin
        if (stage == LAST_STAGE) begin
          state_next = ST_DONE;
        end else begin
          stage_next = stage + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    cmd.stage      = stage;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_MUL:  cmd.mul  = 1'b1;
      ST_DAMP: cmd.damp = 1'b1;
      ST_FILT: cmd.filt = 1'b1;
      ST_AP:   cmd.ap   = 1'b1;
      ST_DONE: begin
        cmd.load = !out_valid || out_ready;
        if (cmd.load) begin
          out_valid_next = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_MUL)
    else $error("accepted pair did not start the multiply step");

  a_ap_from_first: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILT |=> (state == ST_AP && stage == '0))
    else $error("allpass sequence did not start at the first stage");

  a_ap_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_AP && stage == LAST_STAGE) |=> state == ST_DONE)
    else $error("allpass sequence overran the last stage");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared without a finished pair");
`endif

endmodule

FILE: sv/saar_dp.sv
// Datapath of the stereo allpass reverb: registers, multipliers and delay lines.
module saar_dp import saar_pkg::*; #(
  parameter int DELAY_DEPTH  = DELAY_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cmd_t                           cmd,
  output status_t                        status,
  input  logic                           cfg_valid,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [COEF_W-1:0]              cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int IW    = SW + 8;
  localparam int EW    = IW + 3;
  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int RND12 = 2048;
  localparam int RND16 = 32768;

  localparam logic [AW:0]            DEPTH_EXT = (AW+1)'(DELAY_DEPTH);
  localparam logic [AW-1:0]          RP_LAST   = AW'(DELAY_DEPTH - 1);
  localparam logic signed [EW-1:0]   IW_MAX    = {{4{1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [EW-1:0]   IW_MIN    = {{4{1'b1}}, {(IW-1){1'b0}}};
  localparam logic signed [EW-1:0]   SW_MAX    = {{(EW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [EW-1:0]   SW_MIN    = {{(EW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  function automatic logic signed [IW-1:0] sat_iw(input logic signed [EW-1:0] v);
    if (v > IW_MAX) begin
      return IW_MAX[IW-1:0];
    end else if (v < IW_MIN) begin
      return IW_MIN[IW-1:0];
    end
    return v[IW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_sw(input logic signed [EW-1:0] v);
    if (v > SW_MAX) begin
      return SW_MAX[SW-1:0];
    end else if (v < SW_MIN) begin
      return SW_MIN[SW-1:0];
    end
    return v[SW-1:0];
  endfunction

  // Configuration registers; taps held already reduced below the line depth
  logic [COEF_W-1:0] damp_coef, dry_gain, wet_gain, feedback_coef;
  logic [AW-1:0]     tap [STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      damp_coef     <= DAMP_COEF_RST;
      dry_gain      <= DRY_GAIN_RST;
      wet_gain      <= WET_GAIN_RST;
      feedback_coef <= FEEDBACK_COEF_RST;
      for (int k = 0; k < STAGES; k++) begin
        tap[k] <= AW'(tap_mod(int'(TAP_RST[k]), DELAY_DEPTH));
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DAMP_COEF:     damp_coef     <= cfg_data;
        REG_DRY_GAIN:      dry_gain      <= cfg_data;
        REG_WET_GAIN:      wet_gain      <= cfg_data;
        REG_FEEDBACK_COEF: feedback_coef <= cfg_data;
        REG_TAP_ONE:   tap[0] <= AW'(tap_mod(int'(cfg_data[TAP_W-1:0]), DELAY_DEPTH));
        REG_TAP_TWO:   tap[1] <= AW'(tap_mod(int'(cfg_data[TAP_W-1:0]), DELAY_DEPTH));
        REG_TAP_THREE: tap[2] <= AW'(tap_mod(int'(cfg_data[TAP_W-1:0]), DELAY_DEPTH));
        REG_TAP_FOUR:  tap[3] <= AW'(tap_mod(int'(cfg_data[TAP_W-1:0]), DELAY_DEPTH));
        default: ;
      endcase
    end
  end

  // Read position, also the sweep address of the clearing pass
  logic [AW-1:0] rp, rp_next;

  assign rp_next        = (rp == RP_LAST) ? '0 : rp + 1'b1;
  assign status.rp_last = (rp == RP_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
    end else if (cmd.clr || cmd.load) begin
      rp <= rp_next;
    end
  end

  // Delay lines
  logic [AW-1:0]      wr_addr, ram_waddr;
  logic [IW-1:0]      ram_wdata;
  logic [IW-1:0]      rdata [STAGES];
  logic signed [IW-1:0] ap_w, ap_out;

  assign ram_waddr = cmd.clr ? rp : wr_addr;
  assign ram_wdata = cmd.clr ? '0 : ap_w;

  for (genvar k = 0; k < STAGES; k++) begin : g_line
    saar_ram #(
      .WIDTH (IW),
      .DEPTH (DELAY_DEPTH)
    ) u_line (
      .clk   (clk),
      .we    (cmd.clr || (cmd.ap && cmd.stage == STAGE_W'(k))),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.accept),
      .raddr (rp),
      .rdata (rdata[k])
    );
  end

  // Input capture
  logic signed [SW-1:0] a_smp, b_smp;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_smp <= left_in;
      b_smp <= right_in;
    end
  end

  // Multiply step: wet sum, dry gains and the feedback products of all stages
  logic signed [SW:0]      sum_ab;
  logic signed [SW+17:0]   wet_prod;
  logic signed [SW+16:0]   dry_a_prod, dry_b_prod;
  logic signed [IW+16:0]   fb_prod [STAGES];
  logic signed [IW-1:0]    x_val;
  logic signed [SW+4:0]    dry_a, dry_b;
  logic signed [IW-1:0]    t_val [STAGES];
  logic signed [IW:0]      m_val [STAGES];

  assign sum_ab     = (SW+1)'(a_smp) + (SW+1)'(b_smp);
  assign wet_prod   = sum_ab * $signed({1'b0, wet_gain});
  assign dry_a_prod = a_smp * $signed({1'b0, dry_gain});
  assign dry_b_prod = b_smp * $signed({1'b0, dry_gain});

  for (genvar k = 0; k < STAGES; k++) begin : g_fb
    assign fb_prod[k] = $signed(rdata[k]) * $signed({1'b0, feedback_coef});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      x_val <= IW'((wet_prod + RND12) >>> 12);
      dry_a <= (SW+5)'((dry_a_prod + RND12) >>> 12);
      dry_b <= (SW+5)'((dry_b_prod + RND12) >>> 12);
      for (int k = 0; k < STAGES; k++) begin
        t_val[k] <= $signed(rdata[k]);
        m_val[k] <= (IW+1)'((fb_prod[k] + RND16) >>> 16);
      end
    end
  end

  // Damping filter
  logic signed [IW-1:0]  lp, f_val;
  logic signed [IW:0]    damp_diff;
  logic signed [IW+17:0] damp_prod;
  logic signed [IW+1:0]  damp_q;
  logic signed [IW-1:0]  f_next;

  assign damp_diff = (IW+1)'(x_val) - (IW+1)'(lp);
  assign damp_q    = (IW+2)'((damp_prod + RND16) >>> 16);
  assign f_next    = sat_iw(EW'(lp) + EW'(damp_q));

  always_ff @(posedge clk) begin
    if (cmd.damp) begin
      damp_prod <= damp_diff * $signed({1'b0, damp_coef});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp <= '0;
    end else if (cmd.filt) begin
      lp <= f_next;
    end
  end

  // Shared allpass unit, one stage a cycle
  logic signed [IW-1:0] r_val, r_three;
  logic [AW:0]          wr_sum;

  assign ap_w    = sat_iw(EW'(r_val) - EW'(m_val[cmd.stage]));
  assign ap_out  = sat_iw(EW'(ap_w) + EW'(t_val[cmd.stage]));
  assign wr_sum  = (AW+1)'(rp) + (AW+1)'(tap[cmd.stage]);
  assign wr_addr = (wr_sum >= DEPTH_EXT) ? AW'(wr_sum - DEPTH_EXT) : AW'(wr_sum);

  always_ff @(posedge clk) begin
    if (cmd.filt) begin
      f_val <= f_next;
      r_val <= f_next;
    end else if (cmd.ap) begin
      r_val <= ap_out;
    end
    if (cmd.ap && cmd.stage == LEFT_STAGE) begin
      r_three <= ap_out;
    end
  end

  // Output mix and register
  logic signed [EW-1:0] left_sum, right_sum;

  assign left_sum  = EW'(dry_a) + EW'(r_three) - EW'(f_val);
  assign right_sum = EW'(dry_b) + EW'(r_val) - EW'(f_val);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_out  <= sat_sw(left_sum);
      right_out <= sat_sw(right_sum);
    end
  end

endmodule

FILE: sv/stereo_ambience_allpass_reverb.sv
// Top level of the stereo allpass-chain ambience reverb.
//
// Each transfer on the input channel carries one stereo pair (left_in,
// right_in, signed Q1.23 at the default width). The block scales the mono
// sum by wet_gain, smooths it with a one-pole damping filter and runs it
// through four feedback allpass sections, each on its own delay line of
// DELAY_DEPTH entries. left_out mixes the dry left sample with the third
// section's value minus the filter value, right_out does the same with the
// fourth section; both are saturated. One result transfer follows every input
// transfer, in order. Each pair goes through these steps: accepting it reads all
// four delay lines at the shared read position; the multiply step forms the
// wet, dry and feedback products; the damping multiply and then its sum run
// next; the single allpass unit is driven once per section (one delay-line
// write each); and the output register is loaded. The next pair is taken only
// after that load. A finished result waits in the output register while the
// next pair is taken; a second result stalls the block until the first is
// taken. After reset the block sweeps zeros into every delay-line entry and
// takes no input until the sweep is done; configuration writes are taken on
// any cycle (cfg_ready is always high) but should only be issued while no pair
// is in flight. Taps are held modulo DELAY_DEPTH; a tap of zero gives a delay
// of one full line.
module stereo_ambience_allpass_reverb import saar_pkg::*; #(
  parameter int DELAY_DEPTH  = DELAY_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input pair channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [COEF_W-1:0]              cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Register writes never stall
  assign cfg_ready = 1'b1;

  // Sequencer: clearing sweep, accept, multiply, filter, four allpass passes, output load
  saar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, delay lines, configuration and output registers
  saar_dp #(
    .DELAY_DEPTH  (DELAY_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .left_in   (left_in),
    .right_in  (right_in),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule

FILE: tb/reverb_checker.sv
// Scoreboard for the stereo allpass reverb: predicts every result pair and compares it.
`timescale 1ns / 1ps
module reverb_checker import saar_pkg::*; (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0] left_in,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0] right_in,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0] left_out,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0] right_out,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [CFG_INDEX_W-1:0]             cfg_index,
  input  logic [COEF_W-1:0]                  cfg_data,
  output int                                 mismatches,
  output int                                 outstanding,
  output int                                 results_seen
);

  localparam int SW        = SAMPLE_WIDTH_DEF;
  localparam int IW        = SW + 8;
  localparam int DEPTH     = DELAY_DEPTH_DEF;
  localparam int COEF_FRAC = 16;
  localparam int GAIN_FRAC = 12;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } pair_t;

  logic [COEF_W-1:0] damp;
  logic [COEF_W-1:0] dry;
  logic [COEF_W-1:0] wet;
  logic [COEF_W-1:0] fbk;
  logic [TAP_W-1:0]  tap [STAGES];
  longint            line_mem [STAGES][DEPTH];
  longint            lp_state;
  int                rd_pos;
  pair_t             pending_pairs [$];
  pair_t             want;
  int                fail_total = 0;
  int                result_total = 0;

  // Round to nearest with ties upwards, then drop the fraction bits
  function automatic longint scale_round(input longint v, input logic [COEF_W-1:0] coef,
                                         input int sh);
    return (v * longint'(coef) + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Read the line at the shared position before writing, so a zero tap is a full-line delay
  function automatic longint allpass_stage(input int s, input longint x);
    longint held;
    longint fed;
    int     wr;
    wr   = (rd_pos + int'(tap[s])) % DEPTH;
    held = line_mem[s][rd_pos];
    fed  = clamp(x - scale_round(held, fbk, COEF_FRAC), IW);
    line_mem[s][wr] = fed;
    return clamp(fed + held, IW);
  endfunction

  function automatic pair_t predict_pair(input logic signed [SW-1:0] l,
                                         input logic signed [SW-1:0] r);
    longint a;
    longint b;
    longint x;
    longint f;
    longint v;
    longint lsum;
    longint rsum;
    pair_t  res;
    a = longint'(l);
    b = longint'(r);
    x = clamp(scale_round(a + b, wet, GAIN_FRAC), IW);
    f = clamp(lp_state + scale_round(x - lp_state, damp, COEF_FRAC), IW);
    lp_state = f;
    v = allpass_stage(0, f);
    v = allpass_stage(1, v);
    v = allpass_stage(2, v);
    lsum = scale_round(a, dry, GAIN_FRAC) + v - f;
    v = allpass_stage(3, v);
    rsum = scale_round(b, dry, GAIN_FRAC) + v - f;
    rd_pos = (rd_pos + 1) % DEPTH;
    res.left  = SW'(clamp(lsum, SW));
    res.right = SW'(clamp(rsum, SW));
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      damp = DAMP_COEF_RST;
      dry  = DRY_GAIN_RST;
      wet  = WET_GAIN_RST;
      fbk  = FEEDBACK_COEF_RST;
      for (int s = 0; s < STAGES; s++) begin
        tap[s] = TAP_RST[s];
        for (int i = 0; i < DEPTH; i++) begin
          line_mem[s][i] = 0;
        end
      end
      lp_state = 0;
      rd_pos   = 0;
      pending_pairs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DAMP_COEF:     damp = cfg_data;
          REG_DRY_GAIN:      dry = cfg_data;
          REG_WET_GAIN:      wet = cfg_data;
          REG_FEEDBACK_COEF: fbk = cfg_data;
          REG_TAP_ONE:       tap[0] = cfg_data[TAP_W-1:0];
          REG_TAP_TWO:       tap[1] = cfg_data[TAP_W-1:0];
          REG_TAP_THREE:     tap[2] = cfg_data[TAP_W-1:0];
          REG_TAP_FOUR:      tap[3] = cfg_data[TAP_W-1:0];
          default: ;
        endcase
      end
      // Check the result before queueing a new pair: a pair taken now cannot leave now
      if (out_valid && out_ready) begin
        result_total++;
        if (pending_pairs.size() == 0) begin
          $error("unexpected result: left_out %0d right_out %0d", left_out, right_out);
          fail_total++;
        end else begin
          want = pending_pairs.pop_front();
          if (left_out !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, left_out);
            fail_total++;
          end
          if (right_out !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, right_out);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_pairs.push_back(predict_pair(left_in, right_in));
      end
    end
    mismatches   <= fail_total;
    outstanding  <= pending_pairs.size();
    results_seen <= result_total;
  end

endmodule

FILE: tb/stereo_ambience_allpass_reverb_tb.sv
// Testbench top for the stereo allpass reverb: stimulus, idling patterns, watchdog and verdict.
`timescale 1ns / 1ps
module stereo_ambience_allpass_reverb_tb import saar_pkg::*;;

  localparam int SW              = SAMPLE_WIDTH_DEF;
  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 4;
  // Settling time after the last result, with margin over one pair's trip through the block
  localparam int SETTLE_CYCLES   = 20;
  // The limit leaves room for the clearing sweep after reset, which has no transfers
  localparam int QUIET_LIMIT     = 5 * DELAY_DEPTH_DEF;
  localparam int MAX_GAP         = 32;
  localparam int RANDOM_PHASES   = 8;
  localparam int PAIRS_PER_PHASE = 180;
  localparam int QUIET_SPAN      = 1 << 18;
  localparam int TAP_SHORT_MAX   = 48;
  localparam int GAIN_TYPICAL    = 8192;

  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SAMPLE_ALT = {(SW/2){2'b01}};

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = REG_TAP_FOUR + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = '1;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idling_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [SW-1:0]  left_in;
  logic signed [SW-1:0]  right_in;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [SW-1:0]  left_out;
  logic signed [SW-1:0]  right_out;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COEF_W-1:0]     cfg_data;

  int mismatches;
  int outstanding;
  int results_seen;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int pairs_sent     = 0;
  int settings_used  = 1;
  int quiet_cycles   = 0;

  stereo_ambience_allpass_reverb uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  reverb_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_in      (left_in),
    .right_in     (right_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_out     (left_out),
    .right_out    (right_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Result side: stall at random according to the current idling pattern
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: count cycles with no transfer on any channel; give up at the limit
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic void set_idling(input idling_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 48;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 48;
      end
      default: begin
        send_idle_pct  = 38;
        recv_stall_pct = 38;
      end
    endcase
  endfunction

  // Mostly full-scale noise or quiet material, with the rails and zero mixed in
  function automatic logic signed [SW-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3, 4, 5: return SW'($urandom);
      default: return SW'($urandom_range(0, 2 * QUIET_SPAN) - QUIET_SPAN);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] random_coef(input int typical_max);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return COEF_W'($urandom_range(0, typical_max));
    endcase
  endfunction

  // Short taps make the feedback come round within a phase; upper data bits are junk
  function automatic logic [COEF_W-1:0] random_tap();
    logic [COEF_W-1:0] d;
    d = COEF_W'($urandom);
    case ($urandom_range(0, 7))
      0:       d[TAP_W-1:0] = '0;
      1:       d[TAP_W-1:0] = '1;
      2:       d[TAP_W-1:0] = TAP_W'($urandom);
      default: d[TAP_W-1:0] = TAP_W'($urandom_range(1, TAP_SHORT_MAX));
    endcase
    return d;
  endfunction

  // Present one pair after an optional gap; return on the edge that takes it
  task automatic send_pair(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
  endtask

  // Hold cfg_valid high across back-to-back writes; the caller drops it afterwards
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drop valid and hold off until every predicted pair has come back, then let it settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    left_in   <= '0;
    right_in  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    set_idling(IDLE_NONE);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings: rails, zero, sign flips and bit patterns.
    // The first pair waits out the clearing sweep.
    send_pair('0, '0);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(SW'(-1), SW'(1));
    send_pair(SW'(1), SW'(-1));
    send_pair(SAMPLE_ALT, ~SAMPLE_ALT);
    wait_idle();

    // Every gain at full scale to drive internal and output saturation; zero tap,
    // widest tap, a line-depth write that truncates to a zero tap, and writes to unmapped indexes
    write_reg(REG_WET_GAIN, '1);
    write_reg(REG_DRY_GAIN, '1);
    write_reg(REG_DAMP_COEF, '1);
    write_reg(REG_FEEDBACK_COEF, '1);
    write_reg(REG_TAP_ONE, '0);
    write_reg(REG_TAP_TWO, '1);
    write_reg(REG_TAP_THREE, COEF_W'(DELAY_DEPTH_DEF));
    write_reg(REG_TAP_FOUR, COEF_W'(1));
    write_reg(REG_UNMAPPED_LO, '1);
    write_reg(REG_UNMAPPED_HI, '1);
    cfg_valid <= 1'b0;
    settings_used++;
    repeat (4) send_pair(SAMPLE_MAX, SAMPLE_MAX);
    repeat (4) send_pair(SAMPLE_MIN, SAMPLE_MIN);
    repeat (2) begin
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
    end
    wait_idle();

    // All coefficients at zero: only the delay lines' old contents and the held damping value move
    write_reg(REG_WET_GAIN, '0);
    write_reg(REG_DRY_GAIN, '0);
    write_reg(REG_DAMP_COEF, '0);
    write_reg(REG_FEEDBACK_COEF, '0);
    cfg_valid <= 1'b0;
    settings_used++;
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair('0, '0);

    // Random part: fresh settings per phase, cycling through the idling patterns
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      set_idling(idling_t'(ph % 4));
      write_reg(REG_DAMP_COEF, random_coef(int'(COEF_W'('1))));
      write_reg(REG_DRY_GAIN, random_coef(GAIN_TYPICAL));
      write_reg(REG_WET_GAIN, random_coef(GAIN_TYPICAL));
      write_reg(REG_FEEDBACK_COEF, random_coef(int'(COEF_W'('1))));
      write_reg(REG_TAP_ONE, random_tap());
      write_reg(REG_TAP_TWO, random_tap());
      write_reg(REG_TAP_THREE, random_tap());
      write_reg(REG_TAP_FOUR, random_tap());
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_INDEX_W'($urandom_range(int'(REG_UNMAPPED_LO), int'(REG_UNMAPPED_HI))),
                  COEF_W'($urandom));
      end
      cfg_valid <= 1'b0;
      settings_used++;
      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        // Now and then let the block drain completely before the next pair
        if ((ph == 1 && n == PAIRS_PER_PHASE / 2) || $urandom_range(0, 199) == 0) begin
          wait_idle();
        end
        send_pair(random_sample(), random_sample());
      end
    end
    wait_idle();

    $display("Covered %0d stereo pairs under %0d register settings, incl. zero and full-scale",
             pairs_sent, settings_used);
    $display("gains, zero and wrapping taps, and %0d result pairs under four idling patterns",
             results_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
